// File: sv/icl_pkg.sv
package icl_pkg;

  localparam int unsigned CapacityDef  = 64;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned OutBits      = 16;
  localparam int unsigned CmdBits      = 2;
  localparam int unsigned PosBits      = 7;

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_LENGTH = 2'd3
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture command
    logic start;    // check command, set move pointer
    logic grab;     // build result
    logic mv_rd;    // read entry to move
    logic mv_wr;    // write moved entry, step pointer
    logic commit;   // write new entry, update count
  } icl_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic modify;     // command changes the list
    logic move_pend;  // entries left to move
  } icl_stat_t;

endpackage

// File: sv/icl_ctrl.sv
module icl_ctrl
  import icl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  input  icl_stat_t stat_i,
  output icl_ctrl_t ctrl_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_GRAB   = 7'b0000100,
    ST_MV_RD  = 7'b0001000,
    ST_MV_WR  = 7'b0010000,
    ST_FINISH = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // next-state logic
  always_comb begin
    state_d     = state_q;
    s_tready_o  = 1'b0;
    m_tvalid_o  = 1'b0;
    ctrl_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o  = 1'b1;
        ctrl_o.load = s_tvalid_i;
        if (s_tvalid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        ctrl_o.start = 1'b1;
        state_d      = ST_GRAB;
      end
      ST_GRAB: begin
        ctrl_o.grab = 1'b1;
        state_d     = stat_i.modify ? ST_MV_RD : ST_OUT;
      end
      // one entry moves per read/write pair
      ST_MV_RD: begin
        if (stat_i.move_pend) begin
          ctrl_o.mv_rd = 1'b1;
          state_d      = ST_MV_WR;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_MV_WR: begin
        ctrl_o.mv_wr = 1'b1;
        state_d      = ST_MV_RD;
      end
      ST_FINISH: begin
        ctrl_o.commit = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

// File: sv/icl_dp.sv
module icl_dp
  import icl_pkg::*;
#(
  parameter int unsigned Capacity  = CapacityDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icl_ctrl_t            ctrl_i,
  output icl_stat_t            stat_o,
  input  logic [CmdBits-1:0]   cmd_i,
  input  logic [PosBits-1:0]   pos_i,
  input  logic [OutBits-1:0]   cx_i,
  input  logic [OutBits-1:0]   cy_i,
  output logic                 ok_o,
  output logic [OutBits-1:0]   ox_o,
  output logic [OutBits-1:0]   oy_o,
  output logic [PosBits-1:0]   count_o
);

  localparam int unsigned CntBits  = $clog2(Capacity + 1);
  localparam int unsigned AddrBits = $clog2(Capacity);
  localparam int unsigned CmpBits  = (CntBits > PosBits) ? CntBits : PosBits;
  localparam int unsigned Ext = (CoordBits > OutBits) ? CoordBits : OutBits;

  typedef logic [CoordBits-1:0]   crd_t;
  typedef logic [2*CoordBits-1:0] ent_t;   // {y, x}

  // entry memory, one read and one write address per cycle
  ent_t                mem_q [Capacity];
  ent_t                rdata_q;
  logic [CntBits-1:0]  held_q;
  cmd_e                cmd_q;
  logic [PosBits-1:0]  pos_q;
  crd_t                nx_q, ny_q;
  logic [AddrBits-1:0] ptr_q;
  logic                ok_q;
  logic [OutBits-1:0]  ox_q, oy_q;

  // command decode
  logic                pos_lt, pos_le, full, ins_ok, del_ok;
  logic [CmpBits-1:0]  posw, heldw, ptrw;
  logic [AddrBits-1:0] paddr, src, raddr;
  crd_t                rx, ry;
  always_comb begin
    posw   = CmpBits'(pos_q);
    heldw  = CmpBits'(held_q);
    ptrw   = CmpBits'(ptr_q);
    pos_lt = posw < heldw;
    pos_le = posw <= heldw;
    full   = held_q == CntBits'(Capacity);
    ins_ok = (cmd_q == CMD_INSERT) && pos_le && !full;
    del_ok = (cmd_q == CMD_DELETE) && pos_lt;
    paddr  = AddrBits'(pos_q);
    // insert moves entries back from the tail, delete moves them forward
    src    = (cmd_q == CMD_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
    raddr  = ctrl_i.mv_rd ? src : paddr;
    rx     = rdata_q[CoordBits-1:0];
    ry     = rdata_q[2*CoordBits-1:CoordBits];
    stat_o.modify    = ins_ok || del_ok;
    stat_o.move_pend = (cmd_q == CMD_INSERT) ? (ptrw > posw) : (ptrw + 1'b1 < heldw);
  end

  function automatic logic [OutBits-1:0] sx(crd_t v);
    logic [Ext-1:0] w;
    w = Ext'(signed'(v));
    return w[OutBits-1:0];
  endfunction

  // entry memory: moved entry, new entry, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mv_wr) begin
      mem_q[ptr_q] <= rdata_q;
    end else if (ctrl_i.commit && ins_ok) begin
      mem_q[paddr] <= {ny_q, nx_q};
    end
    rdata_q <= mem_q[raddr];
  end

  // captured command, move pointer and result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_e'(cmd_i);
      pos_q <= pos_i;
      nx_q  <= CoordBits'(signed'(cx_i));
      ny_q  <= CoordBits'(signed'(cy_i));
    end
    if (ctrl_i.start) begin
      ptr_q <= (cmd_q == CMD_INSERT) ? AddrBits'(held_q) : paddr;
    end else if (ctrl_i.mv_wr) begin
      ptr_q <= src;
    end
    if (ctrl_i.grab) begin
      ok_q <= 1'b1;
      ox_q <= '0;
      oy_q <= '0;
      unique case (cmd_q)
        CMD_GET, CMD_DELETE: begin
          if (pos_lt) begin
            ox_q <= sx(rx);
            oy_q <= sx(ry);
          end else begin
            ok_q <= 1'b0;
            ox_q <= '1;
          end
        end
        CMD_INSERT: begin
          if (!ins_ok) begin
            ok_q <= 1'b0;
            ox_q <= '1;
          end
        end
        default: ;
      endcase
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) held_q <= '0;
    else if (ctrl_i.commit) begin
      if (ins_ok)      held_q <= held_q + 1'b1;
      else if (del_ok) held_q <= held_q - 1'b1;
    end
  end

  assign ok_o    = ok_q;
  assign ox_o    = ox_q;
  assign oy_o    = oy_q;
  assign count_o = PosBits'(held_q);

endmodule

// File: sv/indexed_coordinate_list.sv
// Indexed coordinate list: get, insert, delete and length query on an ordered list.
// Get, length query and refused commands go from the check and grab states to the result;
// insert and delete also move m entries, one per read and write state pair, then commit.
// One command at a time: the next input transfer can come in the cycle after the result
// transfer, not before.
// Reset (rst_ni low, asynchronous) empties the list; entry contents stay undefined.
module indexed_coordinate_list
  import icl_pkg::*;
#(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [47:0] s_tdata_i,   // cmd[1:0], position[8:2], coord_x[24:9], coord_y[40:25]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o    // ok[0], out_x[16:1], out_y[32:17], count[39:33]
);

  icl_ctrl_t          ctrl;
  icl_stat_t          stat;
  logic               ok;
  logic [OutBits-1:0] ox, oy;
  logic [PosBits-1:0] cnt;

  icl_ctrl u_ctrl (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .m_tvalid_o, .m_tready_i,
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  icl_dp #(.Capacity(CAPACITY), .CoordBits(COORD_BITS)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i (ctrl),
    .stat_o (stat),
    .cmd_i  (s_tdata_i[1:0]),
    .pos_i  (s_tdata_i[8:2]),
    .cx_i   (s_tdata_i[24:9]),
    .cy_i   (s_tdata_i[40:25]),
    .ok_o   (ok),
    .ox_o   (ox),
    .oy_o   (oy),
    .count_o(cnt)
  );

  assign m_tdata_o = {cnt, oy, ox, ok};

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import icl_pkg::*;

  localparam int unsigned Cap       = CapacityDef;
  localparam int unsigned NumRandom = 1600;
  localparam int unsigned IdleLimit = 2000;

  typedef struct packed {
    logic        ok;
    logic [15:0] x;
    logic [15:0] y;
    logic [6:0]  count;
  } coord_result_t;

  typedef struct {
    cmd_e          cmd;
    logic [6:0]    pos;
    logic [15:0]   cx;
    logic [15:0]   cy;
    bit            typed;
    coord_result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [47:0] s_tdata_i = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [39:0] m_tdata_o;

  // predictor state
  logic [15:0]   list_x [Cap];
  logic [15:0]   list_y [Cap];
  int unsigned   list_len = 0;
  coord_result_t pending_results[$];
  int unsigned   errors = 0;
  int unsigned   idle_cycles = 0;
  bit            stim_done = 1'b0;

  always #4 clk_i = ~clk_i;

  indexed_coordinate_list i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  // apply one command to the list model, return its result
  function automatic coord_result_t apply_list_cmd(cmd_e cmd, logic [6:0] pos,
                                                   logic [15:0] cx, logic [15:0] cy);
    coord_result_t r;
    r = '{ok: 1'b0, x: 16'hffff, y: 16'h0, count: 7'd0};
    case (cmd)
      CMD_GET: begin
        if (pos < list_len) r = '{1'b1, list_x[pos], list_y[pos], 7'd0};
      end
      CMD_INSERT: begin
        if (pos <= list_len && list_len < Cap) begin
          for (int k = list_len; k > pos; k--) begin
            list_x[k] = list_x[k-1];
            list_y[k] = list_y[k-1];
          end
          list_x[pos] = cx;
          list_y[pos] = cy;
          list_len++;
          r = '{1'b1, 16'h0, 16'h0, 7'd0};
        end
      end
      CMD_DELETE: begin
        if (pos < list_len) begin
          r = '{1'b1, list_x[pos], list_y[pos], 7'd0};
          for (int k = pos; k + 1 < list_len; k++) begin
            list_x[k] = list_x[k+1];
            list_y[k] = list_y[k+1];
          end
          list_len--;
        end
      end
      default: r = '{1'b1, 16'h0, 16'h0, 7'd0};
    endcase
    r.count = 7'(list_len);
    return r;
  endfunction

  // send one command, predict its result once the transfer completes
  task automatic send_cmd(cmd_e cmd, logic [6:0] pos, logic [15:0] cx, logic [15:0] cy,
                          bit typed, coord_result_t typed_res);
    coord_result_t r;
    int unsigned   idle;
    idle = $urandom_range(0, 3);
    if (idle != 0) begin
      s_tvalid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {7'd0, cy, cx, pos, cmd};
    do @(posedge clk_i); while (!s_tready_o);
    r = apply_list_cmd(cmd, pos, cx, cy);
    if (typed && r !== typed_res) begin
      $error("table row %s pos %0d: expected %h, predicted %h",
             cmd.name(), pos, typed_res, r);
      errors++;
    end
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // result side: random stalls, compare against oldest expectation
  initial begin
    coord_result_t got, want;
    int unsigned   stall;
    stall = 0;
    wait (rst_ni);
    m_tready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o && m_tready_i) begin
        got = m_tdata_o[39:0];
        got = '{m_tdata_o[0], m_tdata_o[16:1], m_tdata_o[32:17], m_tdata_o[39:33]};
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: %h", m_tdata_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok); errors++;
          end
          if (got.x !== want.x) begin
            $error("out_x: expected %h, actual %h", want.x, got.x); errors++;
          end
          if (got.y !== want.y) begin
            $error("out_y: expected %h, actual %h", want.y, got.y); errors++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got.count); errors++;
          end
        end
        stall = $urandom_range(0, 3);
        if (stall != 0) m_tready_i <= 1'b0;
      end else if (!m_tready_i) begin
        stall--;
        if (stall == 0) m_tready_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** indexed_coordinate_list: FAILED **");
      $finish;
    end
  end

  initial begin
    stim_row_t     table_rows[$];
    coord_result_t err_r;
    cmd_e          c;
    logic [6:0]    p;
    int unsigned   roll;
    err_r = '{1'b0, 16'hffff, 16'h0, 7'd0};
    // directed table: empty list errors, extremes, bounds
    table_rows.push_back('{CMD_LENGTH, 7'd0, 16'h0, 16'h0, 1, '{1'b1, 16'h0, 16'h0, 7'd0}});
    table_rows.push_back('{CMD_GET, 7'd0, 16'h0, 16'h0, 1, err_r});
    table_rows.push_back('{CMD_DELETE, 7'd0, 16'h0, 16'h0, 1, err_r});
    table_rows.push_back('{CMD_INSERT, 7'd1, 16'h1234, 16'h1, 1, err_r});
    table_rows.push_back('{CMD_INSERT, 7'd0, 16'h7fff, 16'h8000, 1,
                           '{1'b1, 16'h0, 16'h0, 7'd1}});
    table_rows.push_back('{CMD_INSERT, 7'd0, 16'h8000, 16'h7fff, 1,
                           '{1'b1, 16'h0, 16'h0, 7'd2}});
    table_rows.push_back('{CMD_INSERT, 7'd2, 16'hffff, 16'hffff, 1,
                           '{1'b1, 16'h0, 16'h0, 7'd3}});
    table_rows.push_back('{CMD_GET, 7'd1, 16'h0, 16'h0, 1,
                           '{1'b1, 16'h7fff, 16'h8000, 7'd3}});
    table_rows.push_back('{CMD_GET, 7'd3, 16'h0, 16'h0, 1, '{1'b0, 16'hffff, 16'h0, 7'd3}});
    table_rows.push_back('{CMD_GET, 7'd127, 16'h0, 16'h0, 1, '{1'b0, 16'hffff, 16'h0, 7'd3}});
    table_rows.push_back('{CMD_INSERT, 7'd127, 16'h0, 16'h0, 1,
                           '{1'b0, 16'hffff, 16'h0, 7'd3}});
    table_rows.push_back('{CMD_DELETE, 7'd0, 16'h0, 16'h0, 1,
                           '{1'b1, 16'h8000, 16'h7fff, 7'd2}});
    table_rows.push_back('{CMD_DELETE, 7'd1, 16'h0, 16'h0, 1,
                           '{1'b1, 16'hffff, 16'hffff, 7'd1}});
    table_rows.push_back('{CMD_DELETE, 7'd64, 16'h0, 16'h0, 1,
                           '{1'b0, 16'hffff, 16'h0, 7'd1}});
    table_rows.push_back('{CMD_LENGTH, 7'd127, 16'hffff, 16'hffff, 1,
                           '{1'b1, 16'h0, 16'h0, 7'd1}});
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[i])
      send_cmd(table_rows[i].cmd, table_rows[i].pos, table_rows[i].cx, table_rows[i].cy,
               table_rows[i].typed, table_rows[i].res);
    // fill to capacity, then probe full list and last index
    while (list_len < Cap)
      send_cmd(CMD_INSERT, 7'($urandom_range(0, list_len)), 16'($urandom), 16'($urandom),
               0, err_r);
    send_cmd(CMD_INSERT, 7'd0, 16'h5555, 16'haaaa, 1, '{1'b0, 16'hffff, 16'h0, 7'd64});
    send_cmd(CMD_INSERT, 7'd64, 16'h5555, 16'haaaa, 1, '{1'b0, 16'hffff, 16'h0, 7'd64});
    send_cmd(CMD_GET, 7'd63, 16'h0, 16'h0, 0, err_r);
    send_cmd(CMD_GET, 7'd64, 16'h0, 16'h0, 1, '{1'b0, 16'hffff, 16'h0, 7'd64});
    send_cmd(CMD_DELETE, 7'd63, 16'h0, 16'h0, 0, err_r);
    // random part: mostly valid indexes, drifting length up and down
    for (int n = 0; n < NumRandom; n++) begin
      roll = $urandom_range(0, 99);
      c = cmd_e'($urandom_range(0, 3));
      if (roll < 80)
        p = 7'((c == CMD_INSERT) ? $urandom_range(0, list_len)
               : (list_len == 0 ? 0 : $urandom_range(0, list_len - 1)));
      else
        p = 7'($urandom_range(0, 127));
      if ((n / 200) % 2 == 1 && c == CMD_INSERT && roll < 50) c = CMD_DELETE;
      send_cmd(c, p, 16'($urandom), 16'($urandom), 0, err_r);
    end
    s_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("** indexed_coordinate_list: PASSED **");
    else $display("** indexed_coordinate_list: FAILED **");
    $finish;
  end

endmodule
